>>> design/add_multiply_divide_alu_defines.svh
// Assertion macros shared by the checker
`ifndef ADD_MULTIPLY_DIVIDE_ALU_DEFINES_SVH
`define ADD_MULTIPLY_DIVIDE_ALU_DEFINES_SVH

// Concurrent implication check, reset-qualified
`define AMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication check, reset-qualified
`define AMD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/amd_alu_pkg.sv
package amd_alu_pkg;

    localparam int MAX_WIDTH_DEF = 16;
    localparam int FIELD_W       = 16;
    localparam int CFG_W         = 5;
    localparam int MODE_W        = 3;

    localparam logic [MODE_W-1:0] MODE_UADD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SADD = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UMUL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BMUL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_UDIV = 3'd4;

    // Booth recoding pairs {q0, q-1}
    localparam logic [1:0] BOOTH_SUB = 2'b10;
    localparam logic [1:0] BOOTH_ADD = 2'b01;

    localparam logic [CFG_W-1:0] WIDTH_RESET = 5'd16;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FIELD_W-1:0] operand_a;
        logic [FIELD_W-1:0] operand_b;
    } t_req;

    typedef struct packed {
        logic [FIELD_W-1:0] result_high;
        logic [FIELD_W-1:0] result_low;
        logic               carry_out;
        logic               overflow;
        logic               divide_by_zero;
    } t_rsp;

endpackage

>>> design/amd_cell.sv
// One iteration step for all three iterative modes; registered hand-off.
module amd_cell #(
    parameter int MW = amd_alu_pkg::MAX_WIDTH_DEF,
    parameter int IDX = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic [amd_alu_pkg::MODE_W-1:0] i_mode,
    input  logic [$clog2(MW+1)-1:0]      i_w,
    input  logic [MW-1:0]                i_m,
    input  logic [MW:0]                  i_acc,
    input  logic [MW-1:0]                i_q,
    input  logic                         i_q1,
    output logic                         o_vld,
    output logic [amd_alu_pkg::MODE_W-1:0] o_mode,
    output logic [$clog2(MW+1)-1:0]      o_w,
    output logic [MW-1:0]                o_m,
    output logic [MW:0]                  o_acc,
    output logic [MW-1:0]                o_q,
    output logic                         o_q1
);
    localparam int WW = $clog2(MW+1);

    logic [MW:0]   n_acc;
    logic [MW-1:0] n_q;
    logic          n_q1;
    logic          act;

    always_comb begin
        logic [MW:0]   sum;
        logic [MW:0]   ba;
        logic [MW:0]   rem;
        logic [MW-1:0] qsh;
        logic [MW-1:0] amask;
        logic [MW-1:0] topb;
        logic          qtop;
        sum   = '0;
        ba    = '0;
        rem   = '0;
        qsh   = '0;
        qtop  = 1'b0;
        amask = '1;
        topb  = '0;
        amask = ~({MW{1'b1}} << i_w);
        topb  = MW'(1) << (i_w - WW'(1));
        act   = (WW'(IDX) < i_w);
        n_acc = i_acc;
        n_q   = i_q;
        n_q1  = i_q1;
        case (i_mode)
            amd_alu_pkg::MODE_UMUL: begin
                // acc holds carry in bit w; shift whole {acc,q} right
                sum  = i_q[0] ? (i_acc + {1'b0, i_m}) : i_acc;
                n_q  = ((i_q >> 1) | (sum[0] ? topb : '0)) & amask;
                n_acc = sum >> 1;
            end
            amd_alu_pkg::MODE_BMUL: begin
                ba = i_acc;
                if ({i_q[0], i_q1} == amd_alu_pkg::BOOTH_SUB) begin
                    ba = i_acc - {1'b0, i_m};
                end else if ({i_q[0], i_q1} == amd_alu_pkg::BOOTH_ADD) begin
                    ba = i_acc + {1'b0, i_m};
                end
                ba    = ba & {1'b0, amask};
                n_q1  = i_q[0];
                n_q   = ((i_q >> 1) | (ba[0] ? topb : '0)) & amask;
                n_acc = (ba >> 1) | (ba & {1'b0, topb});
            end
            amd_alu_pkg::MODE_UDIV: begin
                // q holds dividend shifting out at bit w-1, quotient shifting in
                qtop = |(i_q & topb);
                rem  = {i_acc[MW-1:0], qtop};
                qsh  = (i_q << 1) & amask;
                if (rem >= {1'b0, i_m}) begin
                    n_acc = rem - {1'b0, i_m};
                    n_q   = qsh | MW'(1);
                end else begin
                    n_acc = rem;
                    n_q   = qsh;
                end
            end
            default: begin
            end
        endcase
        if (!act) begin
            n_acc = i_acc;
            n_q   = i_q;
            n_q1  = i_q1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
        o_mode <= i_mode;
        o_w    <= i_w;
        o_m    <= i_m;
        o_acc  <= n_acc;
        o_q    <= n_q;
        o_q1   <= n_q1;
    end
endmodule

>>> design/add_multiply_divide_alu.sv
// Channel   Handshake          Payload
// request   i_start / o_busy   i_req  (t_req)
// result    o_done strobe      o_rsp  (t_rsp)
// config    i_cfg_valid / o_cfg_ready  i_cfg_data (operand_width)
// One request per cycle; every mode passes through the entry register,
// the row of MAX_WIDTH iteration cells and the output register.
// o_busy is always low; the receiver cannot stall, so no backpressure exists.
// Synchronous active-low reset clears the pipeline valids and loads WIDTH_RESET into the width register.
module add_multiply_divide_alu #(
    parameter int MAX_WIDTH = amd_alu_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  amd_alu_pkg::t_req             i_req,
    output logic                          o_done,
    output amd_alu_pkg::t_rsp             o_rsp,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [amd_alu_pkg::CFG_W-1:0] i_cfg_data
);
    localparam int MW = MAX_WIDTH;
    localparam int WW = $clog2(MW+1);
    localparam int FW = amd_alu_pkg::FIELD_W;
    localparam int MODE_W = amd_alu_pkg::MODE_W;

    logic [amd_alu_pkg::CFG_W-1:0] r_width;
    logic [WW-1:0] w_eff;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= amd_alu_pkg::WIDTH_RESET;
        end else if (i_cfg_valid) begin
            r_width <= i_cfg_data;
        end
    end

    always_comb begin
        if (32'(r_width) < 2) begin
            w_eff = WW'(2);
        end else if (32'(r_width) > MW) begin
            w_eff = WW'(MW);
        end else begin
            w_eff = WW'(r_width);
        end
    end

    // stage arrays: index 0 is the entry register
    logic              s_vld  [MW+1];
    logic [MODE_W-1:0] s_mode [MW+1];
    logic [WW-1:0]     s_w    [MW+1];
    logic [MW-1:0]     s_m    [MW+1];
    logic [MW:0]       s_acc  [MW+1];
    logic [MW-1:0]     s_q    [MW+1];
    logic              s_q1   [MW+1];
    // add results and divisor-zero flag travel alongside
    logic [MW-1:0]     r_sum  [MW+1];
    logic [2:0]        r_flg  [MW+1];

    logic [MW-1:0] n_sum;
    logic [2:0]    n_flg;
    logic [MW-1:0] n_m;
    logic [MW-1:0] n_q;

    always_comb begin
        logic [MW-1:0] mask;
        logic [MW-1:0] a;
        logic [MW-1:0] b;
        logic [MW:0]   s;
        logic [MW-1:0] topb;
        logic          sa, sb, ss;
        mask = ~({MW{1'b1}} << w_eff);
        topb = MW'(1) << (w_eff - WW'(1));
        a    = MW'(i_req.operand_a) & mask;
        b    = MW'(i_req.operand_b) & mask;
        s    = {1'b0, a} + {1'b0, b};
        sa   = |(a & topb);
        sb   = |(b & topb);
        ss   = |(s[MW-1:0] & topb);
        n_sum = s[MW-1:0] & mask;
        n_flg = '0;
        n_m   = a;
        n_q   = b;
        case (i_req.mode)
            amd_alu_pkg::MODE_UADD: n_flg[2] = |({1'b0, s[MW-1:0]} & ({1'b0, topb} << 1))
                                              | (s[MW] & (w_eff == WW'(MW)));
            amd_alu_pkg::MODE_SADD: n_flg[1] = (sa == sb) && (ss != sa);
            amd_alu_pkg::MODE_UDIV: begin
                n_flg[0] = (b == '0);
                n_m = b;
                n_q = a;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_vld[0] <= 1'b0;
        end else begin
            s_vld[0] <= i_start;
        end
        s_mode[0] <= i_req.mode;
        s_w[0]    <= w_eff;
        s_m[0]    <= n_m;
        s_acc[0]  <= '0;
        s_q[0]    <= n_q;
        s_q1[0]   <= 1'b0;
        r_sum[0]  <= n_sum;
        r_flg[0]  <= n_flg;
    end

    for (genvar g = 0; g < MW; g++) begin : g_cell
        amd_cell #(.MW(MW), .IDX(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (s_vld[g]),
            .i_mode (s_mode[g]),
            .i_w    (s_w[g]),
            .i_m    (s_m[g]),
            .i_acc  (s_acc[g]),
            .i_q    (s_q[g]),
            .i_q1   (s_q1[g]),
            .o_vld  (s_vld[g+1]),
            .o_mode (s_mode[g+1]),
            .o_w    (s_w[g+1]),
            .o_m    (s_m[g+1]),
            .o_acc  (s_acc[g+1]),
            .o_q    (s_q[g+1]),
            .o_q1   (s_q1[g+1])
        );
        always_ff @(posedge i_clk) begin
            r_sum[g+1] <= r_sum[g];
            r_flg[g+1] <= r_flg[g];
        end
    end

    amd_alu_pkg::t_rsp n_rsp;
    logic              r_done;
    amd_alu_pkg::t_rsp r_rsp;

    always_comb begin
        logic [MW-1:0] hi;
        logic [MW-1:0] lo;
        hi    = '0;
        lo    = '0;
        n_rsp = '0;
        case (s_mode[MW])
            amd_alu_pkg::MODE_UADD: begin
                lo = r_sum[MW];
                n_rsp.carry_out = r_flg[MW][2];
            end
            amd_alu_pkg::MODE_SADD: begin
                lo = r_sum[MW];
                n_rsp.overflow = r_flg[MW][1];
            end
            amd_alu_pkg::MODE_UMUL, amd_alu_pkg::MODE_BMUL: begin
                hi = s_acc[MW][MW-1:0];
                lo = s_q[MW];
            end
            amd_alu_pkg::MODE_UDIV: begin
                if (r_flg[MW][0]) begin
                    n_rsp.divide_by_zero = 1'b1;
                end else begin
                    hi = s_acc[MW][MW-1:0];
                    lo = s_q[MW];
                end
            end
            default: begin
            end
        endcase
        n_rsp.result_high = FW'(hi);
        n_rsp.result_low  = FW'(lo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= s_vld[MW];
        end
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;
endmodule

>>> design/amd_checker.sv
`include "add_multiply_divide_alu_defines.svh"

module amd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_done,
    input amd_alu_pkg::t_rsp o_rsp
);
    logic hi_zero;
    logic res_zero;
    logic one_flag;

    assign hi_zero  = (o_rsp.result_high == '0);
    assign res_zero = hi_zero && (o_rsp.result_low == '0);
    assign one_flag = $countones({o_rsp.carry_out, o_rsp.overflow, o_rsp.divide_by_zero}) <= 1;

    `AMD_ASSERT_IMP(a_dz_zero, i_clk, i_rst_n, o_done && o_rsp.divide_by_zero, res_zero)
    `AMD_ASSERT_IMP(a_flags_excl, i_clk, i_rst_n, o_done, one_flag)
    `AMD_ASSERT_IMP(a_start_taken, i_clk, i_rst_n, i_start, !o_busy)
    `AMD_ASSERT_NXT(a_busy_low, i_clk, i_rst_n, !o_busy, !o_busy)
    `AMD_ASSERT_IMP(a_carry_add, i_clk, i_rst_n, o_done && o_rsp.carry_out, hi_zero)
endmodule

bind add_multiply_divide_alu amd_checker u_amd_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_start(i_start),
    .o_busy (o_busy),
    .o_done (o_done),
    .o_rsp  (o_rsp)
);
